>>> design/assert_macros.svh
// Assertion macros used by the checker file mpld_checker.sv.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

>>> design/mpld_pkg.sv
// Package for the multi-pin lockout debouncer: widths, pin count,
// register index codes and the load bundle to the merge stage. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpld_pkg;

	localparam int NUM_PINS = 30;
	localparam int IDX_W    = 5;
	localparam int TIME_W   = 64;
	localparam int DEB_W    = 32;
	localparam int CFG_W    = 32;

	typedef logic [NUM_PINS-1:0] pin_mask_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE_TIME     = 2'd0,
		REG_VALID_PINS        = 2'd1,
		REG_REQUESTED_INPUTS  = 2'd2,
		REG_REQUESTED_OUTPUTS = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic      load;
		pin_mask_t hits;
		pin_mask_t levels;
	} merge_load_t;

endpackage

`default_nettype wire

>>> design/mpld_if.sv
// Valid/ready channel interfaces for the sample input and the change output.
// Depends on mpld_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mpld_sample_if;
	import mpld_pkg::*;
	logic                valid;
	logic                ready;
	logic [NUM_PINS-1:0] pin_levels;
	logic [TIME_W-1:0]   now_us;

	modport source (output valid, output pin_levels, output now_us, input ready);
	modport sink (input valid, input pin_levels, input now_us, output ready);
endinterface

interface mpld_change_if;
	import mpld_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] pin_index;
	logic             pressed;
	logic             last_of_run;

	modport source (output valid, output pin_index, output pressed, output last_of_run,
		input ready);
	modport sink (input valid, input pin_index, input pressed, input last_of_run,
		output ready);
endinterface

`default_nettype wire

>>> design/multi_pin_lockout_debouncer.sv
// Multi-pin lockout debouncer: top level.
// Depends on mpld_pkg, mpld_if, mpld_lane and mpld_merge.
//
// Usage:
//   levels  - sink channel; one transfer carries a 30-pin sample and now_us.
//   changes - source channel; one transfer per accepted pin change, in
//             ascending pin order, last_of_run set on the final one.
//   wr_en/wr_index/wr_data - register writes, taken at any edge with wr_en.
// Timing: a sample is registered at the transfer, the 30 lanes test it the
//   next cycle, and their hits load the merge stage, which moves the accepted
//   changes (0 to 30) into the output register one change per cycle while
//   that register is not held.
//   levels.ready drops after a transfer and returns once every change of
//   that sample has moved into the output register.
// Stall: a held output register freezes the merge walk; nothing is lost.
// Reset: registers, accepted levels and all change times clear to zero;
//   the output channel goes idle.
`timescale 1ns / 1ps
`default_nettype none

module multi_pin_lockout_debouncer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire mpld_pkg::reg_index_t        wr_index,
	input  wire logic [mpld_pkg::CFG_W-1:0]  wr_data,
	mpld_sample_if.sink                      levels,
	mpld_change_if.source                    changes
);
	import mpld_pkg::*;

	logic [DEB_W-1:0]  debounce_q;
	pin_mask_t         valid_pins_q;
	pin_mask_t         req_in_q;
	pin_mask_t         req_out_q;
	pin_mask_t         accepted_q;

	pin_mask_t         sample_s1;
	logic [TIME_W-1:0] now_s1;
	logic              eval_s1;

	pin_mask_t         outs;
	pin_mask_t         ins;
	pin_mask_t         diff;
	pin_mask_t         hits;
	logic              merge_busy;
	merge_load_t       ld;

	assign outs = req_out_q & ~req_in_q & valid_pins_q;
	assign ins  = valid_pins_q & ~outs;
	assign diff = accepted_q ^ sample_s1;

	assign levels.ready = !eval_s1 && !merge_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= '0;
			valid_pins_q <= '0;
			req_in_q     <= '0;
			req_out_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEBOUNCE_TIME:     debounce_q   <= wr_data[DEB_W-1:0];
				REG_VALID_PINS:        valid_pins_q <= wr_data[NUM_PINS-1:0];
				REG_REQUESTED_INPUTS:  req_in_q     <= wr_data[NUM_PINS-1:0];
				REG_REQUESTED_OUTPUTS: req_out_q    <= wr_data[NUM_PINS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1    <= 1'b0;
			accepted_q <= '0;
		end else begin
			eval_s1 <= levels.valid && levels.ready;
			if (eval_s1) begin
				accepted_q <= accepted_q ^ hits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (levels.valid && levels.ready) begin
			sample_s1 <= levels.pin_levels & ins;
			now_s1    <= levels.now_us;
		end
	end

	for (genvar g = 0; g < NUM_PINS; g++) begin : g_lane
		mpld_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.eval     (eval_s1),
			.diff     (diff[g]),
			.now      (now_s1),
			.debounce (debounce_q),
			.hit      (hits[g])
		);
	end

	assign ld.load   = eval_s1;
	assign ld.hits   = hits;
	assign ld.levels = sample_s1;

	mpld_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld      (ld),
		.busy    (merge_busy),
		.changes (changes)
	);

endmodule

`default_nettype wire

>>> design/mpld_lane.sv
// One pin lane: holds the pin's last accepted change time and tests the lockout.
// Depends on mpld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpld_lane (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       eval,
	input  wire logic                       diff,
	input  wire logic [mpld_pkg::TIME_W-1:0] now,
	input  wire logic [mpld_pkg::DEB_W-1:0]  debounce,
	output      logic                       hit
);
	import mpld_pkg::*;

	logic [TIME_W-1:0] last_q;
	logic [TIME_W:0]   deadline;

	// exact sum, no wrap
	assign deadline = {1'b0, last_q} + (TIME_W+1)'(debounce);
	assign hit      = diff && (deadline <= {1'b0, now});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (eval && hit) begin
			last_q <= now;
		end
	end

endmodule

`default_nettype wire

>>> design/mpld_merge.sv
// Merge stage: walks lane hits in ascending pin order through an output register,
// one transfer per cycle while it is not held. Depends on mpld_pkg and mpld_if.
`timescale 1ns / 1ps
`default_nettype none

module mpld_merge (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mpld_pkg::merge_load_t ld,
	output      logic                  busy,
	mpld_change_if.source              changes
);
	import mpld_pkg::*;

	pin_mask_t        pending_q;
	pin_mask_t        levels_q;
	logic             valid_q;
	logic [IDX_W-1:0] index_q;
	logic             pressed_q;
	logic             last_q;

	pin_mask_t        lowest;
	pin_mask_t        rest;
	logic [IDX_W-1:0] lowest_idx;
	logic             advance;

	assign lowest  = pending_q & (~pending_q + pin_mask_t'(1));
	assign rest    = pending_q & ~lowest;
	assign advance = (pending_q != '0) && (!valid_q || changes.ready);
	assign busy    = (pending_q != '0);

	always_comb begin
		lowest_idx = '0;
		for (int i = NUM_PINS - 1; i >= 0; i--) begin
			if (pending_q[i]) begin
				lowest_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (ld.load) begin
				pending_q <= ld.hits;
			end else if (advance) begin
				pending_q <= rest;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (changes.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			levels_q <= ld.levels;
		end
		if (advance) begin
			index_q   <= lowest_idx;
			pressed_q <= ((levels_q & lowest) == '0);
			last_q    <= (rest == '0);
		end
	end

	assign changes.valid       = valid_q;
	assign changes.pin_index   = index_q;
	assign changes.pressed     = pressed_q;
	assign changes.last_of_run = last_q;

endmodule

`default_nettype wire

>>> design/mpld_checker.sv
// Port-level checker for the debouncer, bound to the top level.
// Depends on mpld_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mpld_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [mpld_pkg::IDX_W-1:0] out_pin_index,
	input wire logic                       out_last
);
	import mpld_pkg::*;

	logic in_xfer;
	logic out_stall;

	assign in_xfer   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	`ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready)
	`ASSERT_SAME(a_index_range, out_valid, out_pin_index < IDX_W'(NUM_PINS))
	`ASSERT_NEXT(a_stall_holds, out_stall, out_valid && $stable(out_pin_index) && $stable(out_last))
	`ASSERT_NEXT(a_no_result_right_after_xfer, in_xfer && !out_valid, !out_valid)

endmodule

bind multi_pin_lockout_debouncer mpld_checker u_mpld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (levels.valid),
	.in_ready      (levels.ready),
	.out_valid     (changes.valid),
	.out_ready     (changes.ready),
	.out_pin_index (changes.pin_index),
	.out_last      (changes.last_of_run)
);

`default_nettype wire
